### rtl/sbh_pkg.sv
// Streebog hash package: S-box, linear map and round constant tables,
// and the LPS round function shared by the hash datapath.
// No dependencies.
package sbh_pkg;

  localparam int unsigned NWORDS = 8;
  localparam int unsigned ROUNDS = 12;
  localparam int unsigned STATE_W = 512;
  localparam int unsigned RND_W = 4;

  localparam logic [63:0] IV_WORD_256 = 64'h0101010101010101;

  typedef logic [STATE_W-1:0] blk_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] r;
    case (x)
      8'd0: r = 8'd252; 8'd1: r = 8'd238; 8'd2: r = 8'd221; 8'd3: r = 8'd17;
      8'd4: r = 8'd207; 8'd5: r = 8'd110; 8'd6: r = 8'd49; 8'd7: r = 8'd22;
      8'd8: r = 8'd251; 8'd9: r = 8'd196; 8'd10: r = 8'd250; 8'd11: r = 8'd218;
      8'd12: r = 8'd35; 8'd13: r = 8'd197; 8'd14: r = 8'd4; 8'd15: r = 8'd77;
      8'd16: r = 8'd233; 8'd17: r = 8'd119; 8'd18: r = 8'd240; 8'd19: r = 8'd219;
      8'd20: r = 8'd147; 8'd21: r = 8'd46; 8'd22: r = 8'd153; 8'd23: r = 8'd186;
      8'd24: r = 8'd23; 8'd25: r = 8'd54; 8'd26: r = 8'd241; 8'd27: r = 8'd187;
      8'd28: r = 8'd20; 8'd29: r = 8'd205; 8'd30: r = 8'd95; 8'd31: r = 8'd193;
      8'd32: r = 8'd249; 8'd33: r = 8'd24; 8'd34: r = 8'd101; 8'd35: r = 8'd90;
      8'd36: r = 8'd226; 8'd37: r = 8'd92; 8'd38: r = 8'd239; 8'd39: r = 8'd33;
      8'd40: r = 8'd129; 8'd41: r = 8'd28; 8'd42: r = 8'd60; 8'd43: r = 8'd66;
      8'd44: r = 8'd139; 8'd45: r = 8'd1; 8'd46: r = 8'd142; 8'd47: r = 8'd79;
      8'd48: r = 8'd5; 8'd49: r = 8'd132; 8'd50: r = 8'd2; 8'd51: r = 8'd174;
      8'd52: r = 8'd227; 8'd53: r = 8'd106; 8'd54: r = 8'd143; 8'd55: r = 8'd160;
      8'd56: r = 8'd6; 8'd57: r = 8'd11; 8'd58: r = 8'd237; 8'd59: r = 8'd152;
      8'd60: r = 8'd127; 8'd61: r = 8'd212; 8'd62: r = 8'd211; 8'd63: r = 8'd31;
      8'd64: r = 8'd235; 8'd65: r = 8'd52; 8'd66: r = 8'd44; 8'd67: r = 8'd81;
      8'd68: r = 8'd234; 8'd69: r = 8'd200; 8'd70: r = 8'd72; 8'd71: r = 8'd171;
      8'd72: r = 8'd242; 8'd73: r = 8'd42; 8'd74: r = 8'd104; 8'd75: r = 8'd162;
      8'd76: r = 8'd253; 8'd77: r = 8'd58; 8'd78: r = 8'd206; 8'd79: r = 8'd204;
      8'd80: r = 8'd181; 8'd81: r = 8'd112; 8'd82: r = 8'd14; 8'd83: r = 8'd86;
      8'd84: r = 8'd8; 8'd85: r = 8'd12; 8'd86: r = 8'd118; 8'd87: r = 8'd18;
      8'd88: r = 8'd191; 8'd89: r = 8'd114; 8'd90: r = 8'd19; 8'd91: r = 8'd71;
      8'd92: r = 8'd156; 8'd93: r = 8'd183; 8'd94: r = 8'd93; 8'd95: r = 8'd135;
      8'd96: r = 8'd21; 8'd97: r = 8'd161; 8'd98: r = 8'd150; 8'd99: r = 8'd41;
      8'd100: r = 8'd16; 8'd101: r = 8'd123; 8'd102: r = 8'd154; 8'd103: r = 8'd199;
      8'd104: r = 8'd243; 8'd105: r = 8'd145; 8'd106: r = 8'd120; 8'd107: r = 8'd111;
      8'd108: r = 8'd157; 8'd109: r = 8'd158; 8'd110: r = 8'd178; 8'd111: r = 8'd177;
      8'd112: r = 8'd50; 8'd113: r = 8'd117; 8'd114: r = 8'd25; 8'd115: r = 8'd61;
      8'd116: r = 8'd255; 8'd117: r = 8'd53; 8'd118: r = 8'd138; 8'd119: r = 8'd126;
      8'd120: r = 8'd109; 8'd121: r = 8'd84; 8'd122: r = 8'd198; 8'd123: r = 8'd128;
      8'd124: r = 8'd195; 8'd125: r = 8'd189; 8'd126: r = 8'd13; 8'd127: r = 8'd87;
      8'd128: r = 8'd223; 8'd129: r = 8'd245; 8'd130: r = 8'd36; 8'd131: r = 8'd169;
      8'd132: r = 8'd62; 8'd133: r = 8'd168; 8'd134: r = 8'd67; 8'd135: r = 8'd201;
      8'd136: r = 8'd215; 8'd137: r = 8'd121; 8'd138: r = 8'd214; 8'd139: r = 8'd246;
      8'd140: r = 8'd124; 8'd141: r = 8'd34; 8'd142: r = 8'd185; 8'd143: r = 8'd3;
      8'd144: r = 8'd224; 8'd145: r = 8'd15; 8'd146: r = 8'd236; 8'd147: r = 8'd222;
      8'd148: r = 8'd122; 8'd149: r = 8'd148; 8'd150: r = 8'd176; 8'd151: r = 8'd188;
      8'd152: r = 8'd220; 8'd153: r = 8'd232; 8'd154: r = 8'd40; 8'd155: r = 8'd80;
      8'd156: r = 8'd78; 8'd157: r = 8'd51; 8'd158: r = 8'd10; 8'd159: r = 8'd74;
      8'd160: r = 8'd167; 8'd161: r = 8'd151; 8'd162: r = 8'd96; 8'd163: r = 8'd115;
      8'd164: r = 8'd30; 8'd165: r = 8'd0; 8'd166: r = 8'd98; 8'd167: r = 8'd68;
      8'd168: r = 8'd26; 8'd169: r = 8'd184; 8'd170: r = 8'd56; 8'd171: r = 8'd130;
      8'd172: r = 8'd100; 8'd173: r = 8'd159; 8'd174: r = 8'd38; 8'd175: r = 8'd65;
      8'd176: r = 8'd173; 8'd177: r = 8'd69; 8'd178: r = 8'd70; 8'd179: r = 8'd146;
      8'd180: r = 8'd39; 8'd181: r = 8'd94; 8'd182: r = 8'd85; 8'd183: r = 8'd47;
      8'd184: r = 8'd140; 8'd185: r = 8'd163; 8'd186: r = 8'd165; 8'd187: r = 8'd125;
      8'd188: r = 8'd105; 8'd189: r = 8'd213; 8'd190: r = 8'd149; 8'd191: r = 8'd59;
      8'd192: r = 8'd7; 8'd193: r = 8'd88; 8'd194: r = 8'd179; 8'd195: r = 8'd64;
      8'd196: r = 8'd134; 8'd197: r = 8'd172; 8'd198: r = 8'd29; 8'd199: r = 8'd247;
      8'd200: r = 8'd48; 8'd201: r = 8'd55; 8'd202: r = 8'd107; 8'd203: r = 8'd228;
      8'd204: r = 8'd136; 8'd205: r = 8'd217; 8'd206: r = 8'd231; 8'd207: r = 8'd137;
      8'd208: r = 8'd225; 8'd209: r = 8'd27; 8'd210: r = 8'd131; 8'd211: r = 8'd73;
      8'd212: r = 8'd76; 8'd213: r = 8'd63; 8'd214: r = 8'd248; 8'd215: r = 8'd254;
      8'd216: r = 8'd141; 8'd217: r = 8'd83; 8'd218: r = 8'd170; 8'd219: r = 8'd144;
      8'd220: r = 8'd202; 8'd221: r = 8'd216; 8'd222: r = 8'd133; 8'd223: r = 8'd97;
      8'd224: r = 8'd32; 8'd225: r = 8'd113; 8'd226: r = 8'd103; 8'd227: r = 8'd164;
      8'd228: r = 8'd45; 8'd229: r = 8'd43; 8'd230: r = 8'd9; 8'd231: r = 8'd91;
      8'd232: r = 8'd203; 8'd233: r = 8'd155; 8'd234: r = 8'd37; 8'd235: r = 8'd208;
      8'd236: r = 8'd190; 8'd237: r = 8'd229; 8'd238: r = 8'd108; 8'd239: r = 8'd82;
      8'd240: r = 8'd89; 8'd241: r = 8'd166; 8'd242: r = 8'd116; 8'd243: r = 8'd210;
      8'd244: r = 8'd230; 8'd245: r = 8'd244; 8'd246: r = 8'd180; 8'd247: r = 8'd192;
      8'd248: r = 8'd209; 8'd249: r = 8'd102; 8'd250: r = 8'd175; 8'd251: r = 8'd194;
      8'd252: r = 8'd57; 8'd253: r = 8'd75; 8'd254: r = 8'd99; default: r = 8'd182;
    endcase
    return r;
  endfunction

  localparam logic [63:0] LIN_MAT [64] = '{
    64'h8e20faa72ba0b470, 64'h47107ddd9b505a38, 64'had08b0e0c3282d1c, 64'hd8045870ef14980e,
    64'h6c022c38f90a4c07, 64'h3601161cf205268d, 64'h1b8e0b0e798c13c8, 64'h83478b07b2468764,
    64'ha011d380818e8f40, 64'h5086e740ce47c920, 64'h2843fd2067adea10, 64'h14aff010bdd87508,
    64'h0ad97808d06cb404, 64'h05e23c0468365a02, 64'h8c711e02341b2d01, 64'h46b60f011a83988e,
    64'h90dab52a387ae76f, 64'h486dd4151c3dfdb9, 64'h24b86a840e90f0d2, 64'h125c354207487869,
    64'h092e94218d243cba, 64'h8a174a9ec8121e5d, 64'h4585254f64090fa0, 64'haccc9ca9328a8950,
    64'h9d4df05d5f661451, 64'hc0a878a0a1330aa6, 64'h60543c50de970553, 64'h302a1e286fc58ca7,
    64'h18150f14b9ec46dd, 64'h0c84890ad27623e0, 64'h0642ca05693b9f70, 64'h0321658cba93c138,
    64'h86275df09ce8aaa8, 64'h439da0784e745554, 64'hafc0503c273aa42a, 64'hd960281e9d1d5215,
    64'he230140fc0802984, 64'h71180a8960409a42, 64'hb60c05ca30204d21, 64'h5b068c651810a89e,
    64'h456c34887a3805b9, 64'hac361a443d1c8cd2, 64'h561b0d22900e4669, 64'h2b838811480723ba,
    64'h9bcf4486248d9f5d, 64'hc3e9224312c8c1a0, 64'heffa11af0964ee50, 64'hf97d86d98a327728,
    64'he4fa2054a80b329c, 64'h727d102a548b194e, 64'h39b008152acb8227, 64'h9258048415eb419d,
    64'h492c024284fbaec0, 64'haa16012142f35760, 64'h550b8e9e21f7a530, 64'ha48b474f9ef5dc18,
    64'h70a6a56e2440598e, 64'h3853dc371220a247, 64'h1ca76e95091051ad, 64'h0edd37c48a08a6d8,
    64'h07e095624504536c, 64'h8d70c431ac02a736, 64'hc83862965601dd1b, 64'h641c314b2b8ee083
  };

  localparam blk_t ROUND_C [ROUNDS] = '{
    {64'hb1085bda1ecadae9, 64'hebcb2f81c0657c1f, 64'h2f6a76432e45d016, 64'h714eb88d7585c4fc,
     64'h4b7ce09192676901, 64'ha2422a08a460d315, 64'h05767436cc744d23, 64'hdd806559f2a64507},
    {64'h6fa3b58aa99d2f1a, 64'h4fe39d460f70b5d7, 64'hf3feea720a232b98, 64'h61d55e0f16b50131,
     64'h9ab5176b12d69958, 64'h5cb561c2db0aa7ca, 64'h55dda21bd7cbcd56, 64'he679047021b19bb7},
    {64'hf574dcac2bce2fc7, 64'h0a39fc286a3d8435, 64'h06f15e5f529c1f8b, 64'hf2ea7514b1297b7b,
     64'hd3e20fe490359eb1, 64'hc1c93a376062db09, 64'hc2b6f443867adb31, 64'h991e96f50aba0ab2},
    {64'hef1fdfb3e81566d2, 64'hf948e1a05d71e4dd, 64'h488e857e335c3c7d, 64'h9d721cad685e353f,
     64'ha9d72c82ed03d675, 64'hd8b71333935203be, 64'h3453eaa193e837f1, 64'h220cbebc84e3d12e},
    {64'h4bea6bacad474799, 64'h9a3f410c6ca92363, 64'h7f151c1f1686104a, 64'h359e35d7800fffbd,
     64'hbfcd1747253af5a3, 64'hdfff00b723271a16, 64'h7a56a27ea9ea63f5, 64'h601758fd7c6cfe57},
    {64'hae4faeae1d3ad3d9, 64'h6fa4c33b7a3039c0, 64'h2d66c4f95142a46c, 64'h187f9ab49af08ec6,
     64'hcffaa6b71c9ab7b4, 64'h0af21f66c2bec6b6, 64'hbf71c57236904f35, 64'hfa68407a46647d6e},
    {64'hf4c70e16eeaac5ec, 64'h51ac86febf240954, 64'h399ec6c7e6bf87c9, 64'hd3473e33197a93c9,
     64'h0992abc52d822c37, 64'h06476983284a0504, 64'h3517454ca23c4af3, 64'h8886564d3a14d493},
    {64'h9b1f5b424d93c9a7, 64'h03e7aa020c6e4141, 64'h4eb7f8719c36de1e, 64'h89b4443b4ddbc49a,
     64'hf4892bcb929b0690, 64'h69d18d2bd1a5c42f, 64'h36acc2355951a8d9, 64'ha47f0dd4bf02e71e},
    {64'h378f5a541631229b, 64'h944c9ad8ec165fde, 64'h3a7d3a1b25894224, 64'h3cd955b7e00d0984,
     64'h800a440bdbb2ceb1, 64'h7b2b8a9aa6079c54, 64'h0e38dc92cb1f2a60, 64'h7261445183235adb},
    {64'habbedea680056f52, 64'h382ae548b2e4f3f3, 64'h8941e71cff8a78db, 64'h1fffe18a1b336103,
     64'h9fe76702af69334b, 64'h7a1e6c303b7652f4, 64'h3698fad1153bb6c3, 64'h74b4c7fb98459ced},
    {64'h7bcd9ed0efc889fb, 64'h3002c6cd635afe94, 64'hd8fa6bbbebab0761, 64'h2001802114846679,
     64'h8a1d71efea48b9ca, 64'hefbacd1d7d476e98, 64'hdea2594ac06fd85d, 64'h6bcaa4cd81f32d1b},
    {64'h378ee767f11631ba, 64'hd21380b00449b17a, 64'hcda43c32bcdf1d77, 64'hf82012d430219f9b,
     64'h5d80ef9d1891cc86, 64'he71da4aa88e12852, 64'hfaf417d5d9b21b99, 64'h48bc924af11bd720}
  };

  function automatic logic [63:0] lin_word(input logic [63:0] v);
    logic [63:0] acc;
    acc = '0;
    for (int t = 0; t < 64; t++) begin
      if (v[63-t]) acc = acc ^ LIN_MAT[t];
    end
    return acc;
  endfunction

  // Word 0 sits in bits 511:448.
  function automatic blk_t lps(input blk_t x);
    blk_t y;
    logic [63:0] t;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        t[56-8*c +: 8] = sbox(x[STATE_W-64-64*c + 56-8*r +: 8]);
      end
      y[STATE_W-64-64*r +: 64] = lin_word(t);
    end
    return y;
  endfunction

endpackage

### rtl/sbh_add512.sv
// Iterative 512-bit adder: one 64-bit word per cycle, low word first.
// Depends on sbh_pkg.
module sbh_add512 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sbh_pkg::blk_t a,
  input  sbh_pkg::blk_t b,
  output sbh_pkg::blk_t sum,
  output logic          done
);
  logic [2:0]    idx_r;
  logic          busy_r;
  logic          carry_r;
  sbh_pkg::blk_t sum_r;
  logic [64:0]   wsum;

  assign wsum = {1'b0, a[64*idx_r +: 64]} + {1'b0, b[64*idx_r +: 64]} + {64'd0, carry_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
      carry_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r <= '0;
        carry_r <= 1'b0;
      end else if (busy_r) begin
        sum_r[64*idx_r +: 64] <= wsum[63:0];
        carry_r <= wsum[64];
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sum = sum_r;
endmodule

### rtl/sbh_compress.sv
// Compression function g_N(h, m) with a shared pair of LPS units, one round
// per cycle over the key and state registers. Depends on sbh_pkg.
module sbh_compress (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sbh_pkg::blk_t h,
  input  sbh_pkg::blk_t n,
  input  sbh_pkg::blk_t m,
  output sbh_pkg::blk_t h_out,
  output logic          done
);
  typedef enum logic [1:0] {C_IDLE, C_KEY, C_RND, C_FIN} cst_t;
  cst_t                      st_r;
  logic [sbh_pkg::RND_W-1:0] rnd_r;
  sbh_pkg::blk_t             k_r, s_r, ho_r;
  sbh_pkg::blk_t             lps_k, lps_s, k_nxt;

  assign lps_s = sbh_pkg::lps(s_r);
  assign lps_k = sbh_pkg::lps((st_r == C_KEY) ? k_r : (k_r ^ sbh_pkg::ROUND_C[rnd_r]));
  assign k_nxt = lps_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
      done <= 1'b0;
      rnd_r <= '0;
    end else begin
      done <= 1'b0;
      case (st_r)
        C_IDLE: begin
          if (start) begin
            k_r <= h ^ n;
            st_r <= C_KEY;
          end
        end
        C_KEY: begin
          k_r <= k_nxt;
          s_r <= m ^ k_nxt;
          rnd_r <= '0;
          st_r <= C_RND;
        end
        C_RND: begin
          k_r <= k_nxt;
          s_r <= lps_s ^ k_nxt;
          rnd_r <= rnd_r + sbh_pkg::RND_W'(1);
          if (rnd_r == sbh_pkg::RND_W'(sbh_pkg::ROUNDS - 1)) st_r <= C_FIN;
        end
        C_FIN: begin
          ho_r <= h ^ s_r ^ m;
          done <= 1'b1;
          st_r <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign h_out = ho_r;
endmodule

### rtl/streebog_hash_unit.sv
// Top level of the Streebog hash engine: message sequencer, chain value,
// length and checksum registers. Depends on sbh_pkg, sbh_compress, sbh_add512.
//
// A non-final block keeps in_stall high until its work is done, so a new item is
// taken only after one compression (key load, 12 rounds, final XOR) through the
// shared round unit, with the checksum addition done word-serially by one 64-bit
// adder beside it, then the length addition on the same adder, with handoff
// states between the steps. A final block runs two more compressions after that,
// and then delivers eight or four digest items, one per cycle that out_stall
// is low. in_stall is high whenever a block is in work or a mode write is offered.
module streebog_hash_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_w0,
  input  logic [63:0] in_block_w1,
  input  logic [63:0] in_block_w2,
  input  logic [63:0] in_block_w3,
  input  logic [63:0] in_block_w4,
  input  logic [63:0] in_block_w5,
  input  logic [63:0] in_block_w6,
  input  logic [63:0] in_block_w7,
  input  logic        in_final_block,
  input  logic [8:0]  in_tail_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic        out_digest_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_digest_mode
);
  typedef enum logic [3:0] {
    S_IDLE, S_C1, S_W1, S_A2, S_W2, S_C3, S_W3, S_C4, S_W4, S_OUT
  } st_t;

  st_t           st_r;
  logic          mode_r, fin_r;
  logic [8:0]    tb_r;
  sbh_pkg::blk_t h_r, n_r, sig_r, m_r;
  logic [2:0]    oidx_r;
  logic          c_start, c_done, a_start, a_done;
  sbh_pkg::blk_t c_h, c_n, c_m, c_out, a_a, a_b, a_sum;
  sbh_pkg::blk_t in_blk, pad_blk, iv;
  logic          c_got_r, a_got_r;

  assign in_blk = {in_block_w0, in_block_w1, in_block_w2, in_block_w3,
                   in_block_w4, in_block_w5, in_block_w6, in_block_w7};
  always_comb begin
    for (int i = 0; i < sbh_pkg::STATE_W; i++) begin
      pad_blk[i] = (9'(i) < in_tail_bits) ? in_blk[i] : (9'(i) == in_tail_bits);
    end
  end
  assign iv = {sbh_pkg::NWORDS{mode_r ? sbh_pkg::IV_WORD_256 : 64'd0}};

  assign in_stall  = (st_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_digest_word = h_r[sbh_pkg::STATE_W-64-64*oidx_r +: 64];
  assign out_digest_last = mode_r ? (oidx_r == 3'd3) : (oidx_r == 3'd7);

  assign c_start = (st_r == S_C1) || (st_r == S_C3) || (st_r == S_C4);
  assign c_h = h_r;
  assign c_n = (st_r == S_C1 || st_r == S_W1) ? n_r : '0;
  assign c_m = (st_r == S_C3 || st_r == S_W3) ? n_r :
               (st_r == S_C4 || st_r == S_W4) ? sig_r : m_r;
  assign a_start = (st_r == S_C1) || (st_r == S_A2);
  assign a_a = (st_r == S_A2 || st_r == S_W2) ? n_r : sig_r;
  assign a_b = (st_r == S_A2 || st_r == S_W2) ?
               (fin_r ? sbh_pkg::blk_t'(tb_r) : sbh_pkg::blk_t'(512)) : m_r;

  sbh_compress u_cmp (
    .clk(clk), .rst_n(rst_n), .start(c_start), .h(c_h), .n(c_n), .m(c_m),
    .h_out(c_out), .done(c_done)
  );

  sbh_add512 u_add (
    .clk(clk), .rst_n(rst_n), .start(a_start), .a(a_a), .b(a_b),
    .sum(a_sum), .done(a_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      mode_r <= 1'b0;
      h_r <= '0;
      n_r <= '0;
      sig_r <= '0;
      oidx_r <= '0;
      c_got_r <= 1'b0;
      a_got_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (cfg_valid) begin
            mode_r <= cfg_digest_mode;
            h_r <= {sbh_pkg::NWORDS{cfg_digest_mode ? sbh_pkg::IV_WORD_256 : 64'd0}};
            n_r <= '0;
            sig_r <= '0;
          end else if (in_valid) begin
            m_r <= in_final_block ? pad_blk : in_blk;
            fin_r <= in_final_block;
            tb_r <= in_tail_bits;
            st_r <= S_C1;
          end
        end
        S_C1: begin
          c_got_r <= 1'b0;
          a_got_r <= 1'b0;
          st_r <= S_W1;
        end
        S_W1: begin
          if (c_done) begin
            h_r <= c_out;
            c_got_r <= 1'b1;
          end
          if (a_done) begin
            sig_r <= a_sum;
            a_got_r <= 1'b1;
          end
          if ((c_done || c_got_r) && (a_done || a_got_r)) st_r <= S_A2;
        end
        S_A2: st_r <= S_W2;
        S_W2: begin
          if (a_done) begin
            n_r <= a_sum;
            st_r <= fin_r ? S_C3 : S_IDLE;
          end
        end
        S_C3: st_r <= S_W3;
        S_W3: begin
          if (c_done) begin
            h_r <= c_out;
            st_r <= S_C4;
          end
        end
        S_C4: st_r <= S_W4;
        S_W4: begin
          if (c_done) begin
            h_r <= c_out;
            oidx_r <= '0;
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (out_digest_last) begin
              h_r <= iv;
              n_r <= '0;
              sig_r <= '0;
              st_r <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/streebog_hash_checker.sv
// Checker for the Streebog hash unit: watches the input, result and mode write channels,
// predicts every digest word from its own model of the hash, and compares them.
// Depends on nothing but the channel signals of streebog_hash_unit.
`timescale 1ns / 1ps

module streebog_hash_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_block_w0,
  input  logic [63:0] in_block_w1,
  input  logic [63:0] in_block_w2,
  input  logic [63:0] in_block_w3,
  input  logic [63:0] in_block_w4,
  input  logic [63:0] in_block_w5,
  input  logic [63:0] in_block_w6,
  input  logic [63:0] in_block_w7,
  input  logic        in_final_block,
  input  logic [8:0]  in_tail_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_digest_word,
  input  logic        out_digest_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_digest_mode,
  output int          n_pending,
  output int          n_errors
);

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } digest_item_t;

  localparam logic [7:0] PI_SUB [256] = '{
    252,238,221,17,207,110,49,22,251,196,250,218,35,197,4,77,
    233,119,240,219,147,46,153,186,23,54,241,187,20,205,95,193,
    249,24,101,90,226,92,239,33,129,28,60,66,139,1,142,79,
    5,132,2,174,227,106,143,160,6,11,237,152,127,212,211,31,
    235,52,44,81,234,200,72,171,242,42,104,162,253,58,206,204,
    181,112,14,86,8,12,118,18,191,114,19,71,156,183,93,135,
    21,161,150,41,16,123,154,199,243,145,120,111,157,158,178,177,
    50,117,25,61,255,53,138,126,109,84,198,128,195,189,13,87,
    223,245,36,169,62,168,67,201,215,121,214,246,124,34,185,3,
    224,15,236,222,122,148,176,188,220,232,40,80,78,51,10,74,
    167,151,96,115,30,0,98,68,26,184,56,130,100,159,38,65,
    173,69,70,146,39,94,85,47,140,163,165,125,105,213,149,59,
    7,88,179,64,134,172,29,247,48,55,107,228,136,217,231,137,
    225,27,131,73,76,63,248,254,141,83,170,144,202,216,133,97,
    32,113,103,164,45,43,9,91,203,155,37,208,190,229,108,82,
    89,166,116,210,230,244,180,192,209,102,175,194,57,75,99,182
  };

  localparam logic [63:0] A_MAT [64] = '{
    64'h8e20faa72ba0b470, 64'h47107ddd9b505a38, 64'had08b0e0c3282d1c, 64'hd8045870ef14980e,
    64'h6c022c38f90a4c07, 64'h3601161cf205268d, 64'h1b8e0b0e798c13c8, 64'h83478b07b2468764,
    64'ha011d380818e8f40, 64'h5086e740ce47c920, 64'h2843fd2067adea10, 64'h14aff010bdd87508,
    64'h0ad97808d06cb404, 64'h05e23c0468365a02, 64'h8c711e02341b2d01, 64'h46b60f011a83988e,
    64'h90dab52a387ae76f, 64'h486dd4151c3dfdb9, 64'h24b86a840e90f0d2, 64'h125c354207487869,
    64'h092e94218d243cba, 64'h8a174a9ec8121e5d, 64'h4585254f64090fa0, 64'haccc9ca9328a8950,
    64'h9d4df05d5f661451, 64'hc0a878a0a1330aa6, 64'h60543c50de970553, 64'h302a1e286fc58ca7,
    64'h18150f14b9ec46dd, 64'h0c84890ad27623e0, 64'h0642ca05693b9f70, 64'h0321658cba93c138,
    64'h86275df09ce8aaa8, 64'h439da0784e745554, 64'hafc0503c273aa42a, 64'hd960281e9d1d5215,
    64'he230140fc0802984, 64'h71180a8960409a42, 64'hb60c05ca30204d21, 64'h5b068c651810a89e,
    64'h456c34887a3805b9, 64'hac361a443d1c8cd2, 64'h561b0d22900e4669, 64'h2b838811480723ba,
    64'h9bcf4486248d9f5d, 64'hc3e9224312c8c1a0, 64'heffa11af0964ee50, 64'hf97d86d98a327728,
    64'he4fa2054a80b329c, 64'h727d102a548b194e, 64'h39b008152acb8227, 64'h9258048415eb419d,
    64'h492c024284fbaec0, 64'haa16012142f35760, 64'h550b8e9e21f7a530, 64'ha48b474f9ef5dc18,
    64'h70a6a56e2440598e, 64'h3853dc371220a247, 64'h1ca76e95091051ad, 64'h0edd37c48a08a6d8,
    64'h07e095624504536c, 64'h8d70c431ac02a736, 64'hc83862965601dd1b, 64'h641c314b2b8ee083
  };

  localparam logic [511:0] KEY_C [12] = '{
    {64'hb1085bda1ecadae9, 64'hebcb2f81c0657c1f, 64'h2f6a76432e45d016, 64'h714eb88d7585c4fc,
     64'h4b7ce09192676901, 64'ha2422a08a460d315, 64'h05767436cc744d23, 64'hdd806559f2a64507},
    {64'h6fa3b58aa99d2f1a, 64'h4fe39d460f70b5d7, 64'hf3feea720a232b98, 64'h61d55e0f16b50131,
     64'h9ab5176b12d69958, 64'h5cb561c2db0aa7ca, 64'h55dda21bd7cbcd56, 64'he679047021b19bb7},
    {64'hf574dcac2bce2fc7, 64'h0a39fc286a3d8435, 64'h06f15e5f529c1f8b, 64'hf2ea7514b1297b7b,
     64'hd3e20fe490359eb1, 64'hc1c93a376062db09, 64'hc2b6f443867adb31, 64'h991e96f50aba0ab2},
    {64'hef1fdfb3e81566d2, 64'hf948e1a05d71e4dd, 64'h488e857e335c3c7d, 64'h9d721cad685e353f,
     64'ha9d72c82ed03d675, 64'hd8b71333935203be, 64'h3453eaa193e837f1, 64'h220cbebc84e3d12e},
    {64'h4bea6bacad474799, 64'h9a3f410c6ca92363, 64'h7f151c1f1686104a, 64'h359e35d7800fffbd,
     64'hbfcd1747253af5a3, 64'hdfff00b723271a16, 64'h7a56a27ea9ea63f5, 64'h601758fd7c6cfe57},
    {64'hae4faeae1d3ad3d9, 64'h6fa4c33b7a3039c0, 64'h2d66c4f95142a46c, 64'h187f9ab49af08ec6,
     64'hcffaa6b71c9ab7b4, 64'h0af21f66c2bec6b6, 64'hbf71c57236904f35, 64'hfa68407a46647d6e},
    {64'hf4c70e16eeaac5ec, 64'h51ac86febf240954, 64'h399ec6c7e6bf87c9, 64'hd3473e33197a93c9,
     64'h0992abc52d822c37, 64'h06476983284a0504, 64'h3517454ca23c4af3, 64'h8886564d3a14d493},
    {64'h9b1f5b424d93c9a7, 64'h03e7aa020c6e4141, 64'h4eb7f8719c36de1e, 64'h89b4443b4ddbc49a,
     64'hf4892bcb929b0690, 64'h69d18d2bd1a5c42f, 64'h36acc2355951a8d9, 64'ha47f0dd4bf02e71e},
    {64'h378f5a541631229b, 64'h944c9ad8ec165fde, 64'h3a7d3a1b25894224, 64'h3cd955b7e00d0984,
     64'h800a440bdbb2ceb1, 64'h7b2b8a9aa6079c54, 64'h0e38dc92cb1f2a60, 64'h7261445183235adb},
    {64'habbedea680056f52, 64'h382ae548b2e4f3f3, 64'h8941e71cff8a78db, 64'h1fffe18a1b336103,
     64'h9fe76702af69334b, 64'h7a1e6c303b7652f4, 64'h3698fad1153bb6c3, 64'h74b4c7fb98459ced},
    {64'h7bcd9ed0efc889fb, 64'h3002c6cd635afe94, 64'hd8fa6bbbebab0761, 64'h2001802114846679,
     64'h8a1d71efea48b9ca, 64'hefbacd1d7d476e98, 64'hdea2594ac06fd85d, 64'h6bcaa4cd81f32d1b},
    {64'h378ee767f11631ba, 64'hd21380b00449b17a, 64'hcda43c32bcdf1d77, 64'hf82012d430219f9b,
     64'h5d80ef9d1891cc86, 64'he71da4aa88e12852, 64'hfaf417d5d9b21b99, 64'h48bc924af11bd720}
  };

  logic [511:0] chain_h;
  logic [511:0] length_n;
  logic [511:0] checksum;
  logic         mode_256;
  digest_item_t digest_q[$];

  function automatic logic [63:0] mix_word(input logic [63:0] v);
    logic [63:0] acc;
    acc = '0;
    for (int t = 0; t < 64; t++) begin
      if (v[63-t]) acc = acc ^ A_MAT[t];
    end
    return acc;
  endfunction

  function automatic logic [511:0] lps_round(input logic [511:0] x);
    logic [511:0] y;
    logic [63:0]  row;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        row[56-8*c +: 8] = PI_SUB[x[448-64*c+56-8*r +: 8]];
      end
      y[448-64*r +: 64] = mix_word(row);
    end
    return y;
  endfunction

  function automatic logic [511:0] g_compress(input logic [511:0] n, input logic [511:0] h,
                                              input logic [511:0] m);
    logic [511:0] k;
    logic [511:0] s;
    k = lps_round(h ^ n);
    s = m ^ k;
    for (int i = 0; i < 12; i++) begin
      s = lps_round(s);
      k = lps_round(k ^ KEY_C[i]);
      s = s ^ k;
    end
    return h ^ s ^ m;
  endfunction

  function automatic logic [511:0] start_iv(input logic m256);
    return m256 ? {8{64'h0101010101010101}} : '0;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic absorb_block(input logic [511:0] blk, input logic fin, input logic [8:0] tb);
    logic [511:0] m;
    digest_item_t d;
    int cnt;
    m = blk;
    if (!fin) begin
      chain_h  = g_compress(length_n, chain_h, m);
      length_n = length_n + 512;
      checksum = checksum + m;
    end else begin
      m = (m & ((512'b1 << tb) - 1)) | (512'b1 << tb);
      chain_h  = g_compress(length_n, chain_h, m);
      length_n = length_n + tb;
      checksum = checksum + m;
      chain_h  = g_compress('0, chain_h, length_n);
      chain_h  = g_compress('0, chain_h, checksum);
      cnt = mode_256 ? 4 : 8;
      for (int j = 0; j < cnt; j++) begin
        d.word = chain_h[448-64*j +: 64];
        d.last = (j == cnt - 1);
        digest_q.push_back(d);
      end
      chain_h  = start_iv(mode_256);
      length_n = '0;
      checksum = '0;
    end
  endtask

  initial begin
    n_errors  = 0;
    n_pending = 0;
  end

  always @(posedge clk) begin
    digest_item_t want;
    if (!rst_n) begin
      mode_256 = 1'b0;
      chain_h  = '0;
      length_n = '0;
      checksum = '0;
      digest_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_256 = cfg_digest_mode;
        chain_h  = start_iv(mode_256);
        length_n = '0;
        checksum = '0;
      end
      if (in_valid && !in_stall) begin
        absorb_block({in_block_w0, in_block_w1, in_block_w2, in_block_w3,
                      in_block_w4, in_block_w5, in_block_w6, in_block_w7},
                     in_final_block, in_tail_bits);
      end
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest_word", out_digest_word, 64'd0);
        end else begin
          want = digest_q.pop_front();
          if (out_digest_word !== want.word)
            report_mismatch("digest_word", out_digest_word, want.word);
          if (out_digest_last !== want.last)
            report_mismatch("digest_last", {63'd0, out_digest_last}, {63'd0, want.last});
        end
      end
    end
    n_pending = digest_q.size();
  end

endmodule

### tb/streebog_hash_unit_tb.sv
// Testbench top for streebog_hash_unit: drives directed and random messages in both
// digest modes with random idling and a long output hold, and gives the verdict.
// Depends on streebog_hash_unit and streebog_hash_checker.
`timescale 1ns / 1ps

module streebog_hash_unit_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_block_w0 = '0;
  logic [63:0] in_block_w1 = '0;
  logic [63:0] in_block_w2 = '0;
  logic [63:0] in_block_w3 = '0;
  logic [63:0] in_block_w4 = '0;
  logic [63:0] in_block_w5 = '0;
  logic [63:0] in_block_w6 = '0;
  logic [63:0] in_block_w7 = '0;
  logic        in_final_block = 1'b0;
  logic [8:0]  in_tail_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_digest_word;
  logic        out_digest_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_digest_mode = 1'b0;
  int          n_pending;
  int          n_errors;
  int          items_sent = 0;
  int          hold_cycles = 0;
  bit          calm = 1'b0;

  streebog_hash_unit u_top (.*);

  streebog_hash_checker u_checker (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("streebog_hash_unit verification failed");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 24);
      end
    end
  end

  function automatic logic [511:0] rand_block();
    logic [511:0] b;
    for (int j = 0; j < 8; j++) begin
      case ($urandom_range(9))
        0: b[64*j +: 64] = '0;
        1: b[64*j +: 64] = '1;
        default: b[64*j +: 64] = {$urandom, $urandom};
      endcase
    end
    return b;
  endfunction

  function automatic logic [8:0] rand_tail();
    case ($urandom_range(7))
      0: return 9'd0;
      1: return 9'd511;
      2: return 9'($urandom_range(7) * 64);
      3: return 9'($urandom_range(7) * 64 + 63);
      default: return 9'($urandom_range(511));
    endcase
  endfunction

  task automatic send_block(input logic [511:0] b, input logic fin, input logic [8:0] tb);
    in_valid <= 1'b1;
    {in_block_w0, in_block_w1, in_block_w2, in_block_w3,
     in_block_w4, in_block_w5, in_block_w6, in_block_w7} <= b;
    in_final_block <= fin;
    in_tail_bits <= tb;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_mode(input logic md);
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_digest_mode <= md;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_message(input int n_blocks);
    for (int i = 0; i < n_blocks; i++) send_block(rand_block(), 1'b0, 9'($urandom));
    send_block(rand_block(), 1'b1, rand_tail());
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_block('0, 1'b1, 9'd0);
    send_block('1, 1'b1, 9'd511);
    send_block('1, 1'b0, 9'd511);
    send_block('0, 1'b0, 9'd0);
    send_block(rand_block(), 1'b1, 9'd63);
    send_block('1, 1'b1, 9'd64);
    send_block(rand_block(), 1'b1, 9'd1);
    send_block('1, 1'b1, 9'd448);
    write_mode(1'b1);
    send_block('0, 1'b1, 9'd0);
    send_block('1, 1'b0, 9'd0);
    send_block('1, 1'b1, 9'd511);
    send_block(rand_block(), 1'b0, 9'd5);
    write_mode(1'b1);
    send_block(rand_block(), 1'b1, 9'd256);
    send_block(rand_block(), 1'b0, 9'd100);
    write_mode(1'b0);
    send_block(rand_block(), 1'b1, 9'd255);

    phase = 0;
    while (items_sent < 370) begin
      write_mode(phase < 2 ? phase[0] : 1'($urandom));
      calm = (phase == 3);
      if (phase == 2) hold_cycles = 400;
      repeat (12) begin
        if ($urandom_range(9) == 0) send_message($urandom_range(4, 8));
        else send_message($urandom_range(0, 3));
      end
      if ($urandom_range(3) == 0) send_block(rand_block(), 1'b0, 9'($urandom));
      phase++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("streebog_hash_unit verification clean");
    end else begin
      $display("streebog_hash_unit verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sbh_pkg.sv
rtl/sbh_add512.sv
rtl/sbh_compress.sv
rtl/streebog_hash_unit.sv
tb/streebog_hash_checker.sv
tb/streebog_hash_unit_tb.sv
